/* src/msu_pkg.sv */
package msu_pkg;

	localparam int VEC_W   = 16;
	localparam int FRAC    = 12;
	localparam int PT_W    = 32;
	localparam int ALB_W   = 48;

	localparam int SQ_W    = 2 * VEC_W;
	localparam int ROOT_W  = VEC_W;
	localparam int U_W     = FRAC + 2;
	localparam int QB      = FRAC + 1;
	localparam int DIV_W   = VEC_W + FRAC + 1;
	localparam int DOT_W   = U_W + VEC_W + 2;
	localparam int T_W     = DOT_W + 2 - FRAC;
	localparam int TP_W    = T_W + VEC_W;
	localparam int SAT_W   = TP_W + 2;
	localparam int DN_W    = 2 * VEC_W + 2;

	localparam int SQRT_LAT = ROOT_W + 2;
	localparam int DIV_LAT  = QB;
	localparam int RFL_LAT  = 6;
	localparam int LAT      = SQRT_LAT + DIV_LAT + RFL_LAT;

	typedef enum logic {
		KIND_DIFFUSE = 1'b0,
		KIND_METAL   = 1'b1
	} kind_t;

	typedef enum logic {
		REG_DIFFUSE_ALB = 1'b0,
		REG_METAL_ALB   = 1'b1
	} reg_idx_t;

	typedef logic [VEC_W-1:0] vec_t;
	typedef logic [PT_W-1:0]  pt_t;
	typedef logic [U_W-1:0]   ucomp_t;

	typedef struct packed {
		kind_t      kind;
		vec_t [2:0] v;
		vec_t [2:0] n;
		pt_t  [2:0] pt;
	} hit_t;

	typedef struct packed {
		kind_t      kind;
		pt_t  [2:0] origin;
		vec_t [2:0] dir;
		logic       valid;
	} result_t;

	function automatic vec_t sat_vec(input logic signed [SAT_W-1:0] x);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'($signed({1'b0, {(VEC_W-1){1'b1}}}));
		lo = SAT_W'($signed({1'b1, {(VEC_W-1){1'b0}}}));
		if (x > hi) begin
			return vec_t'(hi);
		end else if (x < lo) begin
			return vec_t'(lo);
		end
		return vec_t'(x);
	endfunction

endpackage

/* src/msu_sqrt.sv */
module msu_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  msu_pkg::hit_t                 in_hit,
	output logic                          out_valid,
	output msu_pkg::hit_t                 out_hit,
	output logic [msu_pkg::ROOT_W-1:0]    out_len
);

	localparam int SQ_W   = msu_pkg::SQ_W;
	localparam int ROOT_W = msu_pkg::ROOT_W;
	localparam int VEC_W  = msu_pkg::VEC_W;

	logic [SQ_W-1:0]  sq_s1 [3];
	logic             vld_s1;
	msu_pkg::hit_t    hit_s1;
	logic [SQ_W-1:0]  sum_s2;
	logic             vld_s2;
	msu_pkg::hit_t    hit_s2;

	logic [VEC_W-1:0] mag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = in_hit.v[i][VEC_W-1] ? (~in_hit.v[i] + VEC_W'(1)) : in_hit.v[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s1[i] <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
		end
		hit_s1 <= in_hit;
		sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		hit_s2 <= hit_s1;
	end

	// one root bit per stage, digit-by-digit
	logic [SQ_W-1:0] rem_s  [ROOT_W+1];
	logic [SQ_W-1:0] root_s [ROOT_W+1];
	logic            vld_s  [ROOT_W+1];
	msu_pkg::hit_t   hit_s  [ROOT_W+1];

	assign rem_s[0]  = sum_s2;
	assign root_s[0] = '0;
	assign vld_s[0]  = vld_s2;
	assign hit_s[0]  = hit_s2;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_root
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - j));
		logic [SQ_W:0]   trial;
		logic [SQ_W-1:0] rem_nx;
		logic [SQ_W-1:0] root_nx;

		always_comb begin
			trial = {1'b0, root_s[j]} + {1'b0, BIT};
			if ({1'b0, rem_s[j]} >= trial) begin
				rem_nx  = rem_s[j] - trial[SQ_W-1:0];
				root_nx = (root_s[j] >> 1) + BIT;
			end else begin
				rem_nx  = rem_s[j];
				root_nx = root_s[j] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1]  <= rem_nx;
			root_s[j+1] <= root_nx;
			hit_s[j+1]  <= hit_s[j];
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign out_hit   = hit_s[ROOT_W];
	assign out_len   = root_s[ROOT_W][ROOT_W-1:0];

endmodule

/* src/msu_div.sv */
module msu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  msu_pkg::hit_t               in_hit,
	input  logic [msu_pkg::ROOT_W-1:0]  in_len,
	output logic                        out_valid,
	output msu_pkg::hit_t               out_hit,
	output msu_pkg::ucomp_t             out_u [3]
);

	localparam int QB     = msu_pkg::QB;
	localparam int DIV_W  = msu_pkg::DIV_W;
	localparam int VEC_W  = msu_pkg::VEC_W;
	localparam int ROOT_W = msu_pkg::ROOT_W;
	localparam int FRAC   = msu_pkg::FRAC;
	localparam int U_W    = msu_pkg::U_W;

	logic [DIV_W-1:0]  rem_s [QB+1][3];
	logic [QB-1:0]     quo_s [QB+1][3];
	logic              vld_s [QB+1];
	msu_pkg::hit_t     hit_s [QB+1];
	logic [ROOT_W-1:0] len_s [QB+1];
	logic [VEC_W-1:0]  mag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = in_hit.v[i][VEC_W-1] ? (~in_hit.v[i] + VEC_W'(1)) : in_hit.v[i];
			rem_s[0][i] = DIV_W'(mag[i]) << FRAC;
			quo_s[0][i] = '0;
		end
	end
	assign vld_s[0] = in_valid;
	assign hit_s[0] = in_hit;
	assign len_s[0] = in_len;

	// restoring division, one quotient bit per stage, three lanes
	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int K = QB - 1 - j;
		logic [DIV_W-1:0] den;
		logic [DIV_W-1:0] rem_nx [3];
		logic [QB-1:0]    quo_nx [3];

		always_comb begin
			den = DIV_W'(len_s[j]) << K;
			for (int i = 0; i < 3; i++) begin
				rem_nx[i] = rem_s[j][i];
				quo_nx[i] = quo_s[j][i];
				if (rem_s[j][i] >= den) begin
					rem_nx[i]    = rem_s[j][i] - den;
					quo_nx[i][K] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[j+1][i] <= rem_nx[i];
				quo_s[j+1][i] <= quo_nx[i];
			end
			hit_s[j+1] <= hit_s[j];
			len_s[j+1] <= len_s[j];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (len_s[QB] == '0) begin
				out_u[i] = '0;
			end else if (hit_s[QB].v[i][VEC_W-1]) begin
				out_u[i] = ~U_W'(quo_s[QB][i]) + U_W'(1);
			end else begin
				out_u[i] = U_W'(quo_s[QB][i]);
			end
		end
	end

	assign out_valid = vld_s[QB];
	assign out_hit   = hit_s[QB];

endmodule

/* src/msu_reflect.sv */
module msu_reflect (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  msu_pkg::hit_t     in_hit,
	input  msu_pkg::ucomp_t   in_u [3],
	output logic              out_valid,
	output msu_pkg::result_t  out_res
);

	localparam int VEC_W = msu_pkg::VEC_W;
	localparam int U_W   = msu_pkg::U_W;
	localparam int FRAC  = msu_pkg::FRAC;
	localparam int DOT_W = msu_pkg::DOT_W;
	localparam int T_W   = msu_pkg::T_W;
	localparam int TP_W  = msu_pkg::TP_W;
	localparam int SAT_W = msu_pkg::SAT_W;
	localparam int DN_W  = msu_pkg::DN_W;
	localparam int Q_W   = TP_W + 1 - FRAC;
	localparam int DF_W  = Q_W + 1;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	msu_pkg::hit_t                 hit_s1, hit_s2, hit_s3, hit_s4, hit_s5;
	msu_pkg::ucomp_t               u_s1 [3];
	msu_pkg::ucomp_t               u_s2 [3];
	msu_pkg::ucomp_t               u_s3 [3];
	logic signed [U_W+VEC_W-1:0]   prod_s1 [3];
	logic signed [VEC_W:0]         sumd_s1 [3];
	logic signed [T_W-1:0]         t_s2;
	msu_pkg::vec_t                 ddir_s2 [3];
	msu_pkg::vec_t                 ddir_s3 [3];
	logic signed [TP_W-1:0]        tp_s3 [3];
	msu_pkg::vec_t                 dir_s4 [3];
	msu_pkg::vec_t                 dir_s5 [3];
	logic signed [2*VEC_W-1:0]     dn_s5 [3];
	msu_pkg::result_t              res_s6;

	// stage 2: dot, reflection scale, diffuse direction
	logic signed [DOT_W-1:0]   dot;
	logic signed [DOT_W+1:0]   dot2;
	logic                      sum_zero;
	msu_pkg::vec_t             ddir [3];

	always_comb begin
		dot  = DOT_W'(prod_s1[0]) + DOT_W'(prod_s1[1]) + DOT_W'(prod_s1[2]);
		dot2 = (DOT_W+2)'(dot) <<< 1;
		if (dot2 < 0) begin
			dot2 = dot2 + (DOT_W+2)'((1 << FRAC) - 1);
		end
		sum_zero = (sumd_s1[0] == '0) && (sumd_s1[1] == '0) && (sumd_s1[2] == '0);
		for (int i = 0; i < 3; i++) begin
			ddir[i] = sum_zero ? hit_s1.n[i] : msu_pkg::sat_vec(SAT_W'(sumd_s1[i]));
		end
	end

	// stage 4: mirror direction
	logic signed [TP_W:0]      tpa [3];
	logic signed [Q_W-1:0]     qt [3];
	logic signed [DF_W-1:0]    diff [3];
	msu_pkg::vec_t             dir_nx [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tpa[i] = (TP_W+1)'(tp_s3[i]);
			if (tp_s3[i] < 0) begin
				tpa[i] = tpa[i] + (TP_W+1)'((1 << FRAC) - 1);
			end
			qt[i]   = Q_W'(tpa[i] >>> FRAC);
			diff[i] = DF_W'($signed(u_s3[i])) - DF_W'(qt[i]);
			unique case (hit_s3.kind)
				msu_pkg::KIND_METAL:   dir_nx[i] = msu_pkg::sat_vec(SAT_W'(diff[i]));
				msu_pkg::KIND_DIFFUSE: dir_nx[i] = ddir_s3[i];
			endcase
		end
	end

	logic signed [DN_W-1:0] dn_sum;
	assign dn_sum = DN_W'(dn_s5[0]) + DN_W'(dn_s5[1]) + DN_W'(dn_s5[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s1[i] <= (U_W+VEC_W)'($signed(in_u[i])) * (U_W+VEC_W)'($signed(in_hit.n[i]));
			sumd_s1[i] <= (VEC_W+1)'($signed(in_hit.n[i])) + (VEC_W+1)'($signed(in_u[i]));
			u_s1[i]    <= in_u[i];
			u_s2[i]    <= u_s1[i];
			u_s3[i]    <= u_s2[i];
			ddir_s2[i] <= ddir[i];
			ddir_s3[i] <= ddir_s2[i];
			tp_s3[i]   <= TP_W'(t_s2) * TP_W'($signed(hit_s2.n[i]));
			dir_s4[i]  <= dir_nx[i];
			dir_s5[i]  <= dir_s4[i];
			dn_s5[i]   <= (2*VEC_W)'($signed(dir_s4[i])) * (2*VEC_W)'($signed(hit_s4.n[i]));
		end
		t_s2   <= T_W'(dot2 >>> FRAC);
		hit_s1 <= in_hit;
		hit_s2 <= hit_s1;
		hit_s3 <= hit_s2;
		hit_s4 <= hit_s3;
		hit_s5 <= hit_s4;
		res_s6.kind   <= hit_s5.kind;
		res_s6.origin <= hit_s5.pt;
		for (int i = 0; i < 3; i++) begin
			res_s6.dir[i] <= dir_s5[i];
		end
		res_s6.valid  <= (hit_s5.kind == msu_pkg::KIND_DIFFUSE) || (dn_sum > 0);
	end

	assign out_valid = vld_s6;
	assign out_res   = res_s6;

endmodule

/* src/material_scatter_unit_top.sv */
// pipeline from start to done: square/sum, root, divide and scatter stages
// throughput: one item per cycle, fully pipelined, busy is always low
// the receiver cannot stall; done pulses for one cycle per item
// reset: arst_n clears the pipeline valid bits and both albedo registers
module material_scatter_unit_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         cfg_we,
	input  logic                         cfg_idx,
	input  logic [msu_pkg::ALB_W-1:0]    cfg_wdata,
	input  logic                         kind,
	input  logic signed [msu_pkg::VEC_W-1:0] vec_x,
	input  logic signed [msu_pkg::VEC_W-1:0] vec_y,
	input  logic signed [msu_pkg::VEC_W-1:0] vec_z,
	input  logic signed [msu_pkg::VEC_W-1:0] normal_x,
	input  logic signed [msu_pkg::VEC_W-1:0] normal_y,
	input  logic signed [msu_pkg::VEC_W-1:0] normal_z,
	input  logic signed [msu_pkg::PT_W-1:0]  point_x,
	input  logic signed [msu_pkg::PT_W-1:0]  point_y,
	input  logic signed [msu_pkg::PT_W-1:0]  point_z,
	output logic                         done,
	output logic signed [msu_pkg::PT_W-1:0]  origin_x,
	output logic signed [msu_pkg::PT_W-1:0]  origin_y,
	output logic signed [msu_pkg::PT_W-1:0]  origin_z,
	output logic signed [msu_pkg::VEC_W-1:0] out_dir_x,
	output logic signed [msu_pkg::VEC_W-1:0] out_dir_y,
	output logic signed [msu_pkg::VEC_W-1:0] out_dir_z,
	output logic [msu_pkg::ALB_W-1:0]    attenuation_rgb,
	output logic                         valid_res
);

	logic [msu_pkg::ALB_W-1:0] diffuse_alb_q;
	logic [msu_pkg::ALB_W-1:0] metal_alb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diffuse_alb_q <= '0;
			metal_alb_q   <= '0;
		end else if (cfg_we) begin
			unique case (msu_pkg::reg_idx_t'(cfg_idx))
				msu_pkg::REG_DIFFUSE_ALB: diffuse_alb_q <= cfg_wdata;
				msu_pkg::REG_METAL_ALB:   metal_alb_q   <= cfg_wdata;
			endcase
		end
	end

	assign busy = 1'b0;

	logic              acc;
	msu_pkg::hit_t     in_hit;

	assign acc           = start && !busy;
	assign in_hit.kind   = msu_pkg::kind_t'(kind);
	assign in_hit.v[0]   = vec_x;
	assign in_hit.v[1]   = vec_y;
	assign in_hit.v[2]   = vec_z;
	assign in_hit.n[0]   = normal_x;
	assign in_hit.n[1]   = normal_y;
	assign in_hit.n[2]   = normal_z;
	assign in_hit.pt[0]  = point_x;
	assign in_hit.pt[1]  = point_y;
	assign in_hit.pt[2]  = point_z;

	logic                          sq_valid;
	msu_pkg::hit_t                 sq_hit;
	logic [msu_pkg::ROOT_W-1:0]    sq_len;
	logic                          dv_valid;
	msu_pkg::hit_t                 dv_hit;
	msu_pkg::ucomp_t               dv_u [3];
	logic                          rf_valid;
	msu_pkg::result_t              rf_res;

	msu_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (acc),
		.in_hit    (in_hit),
		.out_valid (sq_valid),
		.out_hit   (sq_hit),
		.out_len   (sq_len)
	);

	msu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_hit    (sq_hit),
		.in_len    (sq_len),
		.out_valid (dv_valid),
		.out_hit   (dv_hit),
		.out_u     (dv_u)
	);

	msu_reflect u_reflect (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_hit    (dv_hit),
		.in_u      (dv_u),
		.out_valid (rf_valid),
		.out_res   (rf_res)
	);

	assign done      = rf_valid;
	assign origin_x  = rf_res.origin[0];
	assign origin_y  = rf_res.origin[1];
	assign origin_z  = rf_res.origin[2];
	assign out_dir_x = rf_res.dir[0];
	assign out_dir_y = rf_res.dir[1];
	assign out_dir_z = rf_res.dir[2];
	assign valid_res = rf_res.valid;

	// the user must write the albedo registers only while the pipe is empty; the block does not enforce it
	assign attenuation_rgb = (rf_res.kind == msu_pkg::KIND_METAL) ? metal_alb_q : diffuse_alb_q;

`ifndef SYNTHESIS
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, msu_pkg::LAT))
		else $error("done without an accepted item");

	a_diffuse_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rf_res.kind == msu_pkg::KIND_DIFFUSE) |-> valid_res)
		else $error("diffuse result dropped");

	a_origin_kept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (origin_x == $past(point_x, msu_pkg::LAT)))
		else $error("origin does not match hit point");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

	localparam int HALF_PERIOD = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PER_PHASE = 340;
	localparam int DRAIN_CYCLES = msu_pkg::LAT + 8;

	typedef struct {
		msu_pkg::kind_t         kind;
		logic signed [15:0]     v [3];
		logic signed [15:0]     n [3];
		logic signed [31:0]     pt [3];
	} hit_item_t;

	typedef struct {
		logic [31:0] origin [3];
		logic [15:0] dir [3];
		logic [47:0] att;
		logic        valid;
	} scatter_res_t;

	class scatter_board;
		logic [47:0]  albedo [2];
		scatter_res_t pending [$];
		int           errors;

		function new();
			albedo[0] = '0;
			albedo[1] = '0;
			errors = 0;
		endfunction

		function void set_albedo(msu_pkg::reg_idx_t idx, logic [47:0] val);
			albedo[idx] = val;
		endfunction

		static function longint unsigned int_sqrt(longint unsigned num);
			longint unsigned res;
			longint unsigned bv;
			res = 0;
			bv = 64'h4000_0000_0000_0000;
			while (bv > num) bv = bv >> 2;
			while (bv != 0) begin
				if (num >= res + bv) begin
					num = num - (res + bv);
					res = (res >> 1) + bv;
				end else begin
					res = res >> 1;
				end
				bv = bv >> 2;
			end
			return res;
		endfunction

		static function longint clamp_vec(longint x);
			if (x > 32767) return 32767;
			if (x < -32768) return -32768;
			return x;
		endfunction

		function scatter_res_t predict_scatter(hit_item_t h);
			scatter_res_t r;
			longint v [3];
			longint n [3];
			longint u [3];
			longint d [3];
			longint s [3];
			longint len;
			longint dot;
			longint t;
			v[0] = h.v[0]; v[1] = h.v[1]; v[2] = h.v[2];
			n[0] = h.n[0]; n[1] = h.n[1]; n[2] = h.n[2];
			len = longint'(int_sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]));
			for (int i = 0; i < 3; i++) u[i] = (len == 0) ? 0 : (v[i] * 4096) / len;
			if (h.kind == msu_pkg::KIND_DIFFUSE) begin
				for (int i = 0; i < 3; i++) s[i] = n[i] + u[i];
				// sum cancels exactly: fall back to the normal
				if (s[0] == 0 && s[1] == 0 && s[2] == 0) begin
					for (int i = 0; i < 3; i++) d[i] = n[i];
				end else begin
					for (int i = 0; i < 3; i++) d[i] = clamp_vec(s[i]);
				end
				r.valid = 1'b1;
			end else begin
				dot = u[0] * n[0] + u[1] * n[1] + u[2] * n[2];
				t = (2 * dot) / 4096;
				if (t > 64'sd2147483647) t = 64'sd2147483647;
				if (t < -64'sd2147483648) t = -64'sd2147483648;
				for (int i = 0; i < 3; i++) d[i] = clamp_vec(u[i] - (t * n[i]) / 4096);
				r.valid = (d[0] * n[0] + d[1] * n[1] + d[2] * n[2]) > 0;
			end
			for (int i = 0; i < 3; i++) begin
				r.origin[i] = h.pt[i];
				r.dir[i] = d[i][15:0];
			end
			r.att = albedo[h.kind];
			return r;
		endfunction

		function void note_hit(hit_item_t h);
			pending.push_back(predict_scatter(h));
		endfunction

		function void check_result(scatter_res_t got);
			scatter_res_t e;
			if (pending.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			for (int i = 0; i < 3; i++) begin
				if (got.origin[i] !== e.origin[i]) begin
					$error("origin[%0d] expected %h got %h", i, e.origin[i], got.origin[i]);
					errors++;
				end
				if (got.dir[i] !== e.dir[i]) begin
					$error("out_dir[%0d] expected %h got %h", i, e.dir[i], got.dir[i]);
					errors++;
				end
			end
			if (got.att !== e.att) begin
				$error("attenuation_rgb expected %h got %h", e.att, got.att);
				errors++;
			end
			if (got.valid !== e.valid) begin
				$error("valid_res expected %b got %b", e.valid, got.valid);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic cfg_we;
	msu_pkg::reg_idx_t cfg_idx;
	logic [msu_pkg::ALB_W-1:0] cfg_wdata;
	msu_pkg::kind_t kind;
	logic signed [msu_pkg::VEC_W-1:0] vec_x, vec_y, vec_z;
	logic signed [msu_pkg::VEC_W-1:0] normal_x, normal_y, normal_z;
	logic signed [msu_pkg::PT_W-1:0] point_x, point_y, point_z;
	logic done;
	logic signed [msu_pkg::PT_W-1:0] origin_x, origin_y, origin_z;
	logic signed [msu_pkg::VEC_W-1:0] out_dir_x, out_dir_y, out_dir_z;
	logic [msu_pkg::ALB_W-1:0] attenuation_rgb;
	logic valid_res;

	scatter_board board;
	int cycles;

	material_scatter_unit_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.kind(kind), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.done(done), .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z),
		.attenuation_rgb(attenuation_rgb), .valid_res(valid_res)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// results checked before the item of the same edge is noted
	always @(posedge clk) begin
		scatter_res_t got;
		hit_item_t h;
		if (arst_n) begin
			if (done) begin
				got.origin[0] = origin_x; got.origin[1] = origin_y; got.origin[2] = origin_z;
				got.dir[0] = out_dir_x; got.dir[1] = out_dir_y; got.dir[2] = out_dir_z;
				got.att = attenuation_rgb;
				got.valid = valid_res;
				board.check_result(got);
			end
			if (start && !busy) begin
				h.kind = kind;
				h.v[0] = vec_x; h.v[1] = vec_y; h.v[2] = vec_z;
				h.n[0] = normal_x; h.n[1] = normal_y; h.n[2] = normal_z;
				h.pt[0] = point_x; h.pt[1] = point_y; h.pt[2] = point_z;
				board.note_hit(h);
			end
		end
	end

	task automatic send_hit(hit_item_t h);
		@(negedge clk);
		start = 1'b1;
		kind = h.kind;
		vec_x = h.v[0]; vec_y = h.v[1]; vec_z = h.v[2];
		normal_x = h.n[0]; normal_y = h.n[1]; normal_z = h.n[2];
		point_x = h.pt[0]; point_y = h.pt[1]; point_z = h.pt[2];
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
	endtask

	task automatic pause_sender(int n);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		pause_sender(1);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_albedo(msu_pkg::reg_idx_t idx, logic [47:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = 48'({$urandom, $urandom});
		board.set_albedo(idx, val);
	endtask

	function automatic hit_item_t make_hit(msu_pkg::kind_t k, int vx, int vy, int vz,
		int nx, int ny, int nz);
		hit_item_t h;
		h.kind = k;
		h.v[0] = 16'(vx); h.v[1] = 16'(vy); h.v[2] = 16'(vz);
		h.n[0] = 16'(nx); h.n[1] = 16'(ny); h.n[2] = 16'(nz);
		for (int i = 0; i < 3; i++) h.pt[i] = $urandom;
		return h;
	endfunction

	function automatic int small_comp(int mag);
		return $urandom_range(2 * mag) - mag;
	endfunction

	function automatic hit_item_t random_hit();
		hit_item_t h;
		int sel;
		h.kind = msu_pkg::kind_t'($urandom_range(1));
		sel = $urandom_range(99);
		for (int i = 0; i < 3; i++) h.pt[i] = $urandom;
		if (sel < 60) begin
			// plausible hit: near-unit normal, moderate vector
			for (int i = 0; i < 3; i++) begin
				h.n[i] = 16'(small_comp(4096));
				h.v[i] = 16'(small_comp(8192));
			end
		end else if (sel < 85) begin
			for (int i = 0; i < 3; i++) begin
				h.n[i] = 16'($urandom);
				h.v[i] = 16'($urandom);
			end
		end else if (sel < 93) begin
			// incoming vector opposite the normal, diffuse sum may cancel
			for (int i = 0; i < 3; i++) begin
				h.n[i] = 16'(small_comp(4096));
				h.v[i] = -h.n[i];
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				h.n[i] = 16'($urandom);
				h.v[i] = '0;
			end
		end
		return h;
	endfunction

	task automatic run_random(int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 30);
			while (burst > 0 && count > 0) begin
				send_hit(random_hit());
				burst--;
				count--;
			end
			if ($urandom_range(3) != 0) pause_sender($urandom_range(1, 12));
		end
	endtask

	task automatic run_directed();
		send_hit(make_hit(msu_pkg::KIND_DIFFUSE, 0, 0, 0, 4096, 0, 0));
		send_hit(make_hit(msu_pkg::KIND_METAL, 0, 0, 0, 0, 4096, 0));
		send_hit(make_hit(msu_pkg::KIND_DIFFUSE, -4096, 0, 0, 4096, 0, 0));
		send_hit(make_hit(msu_pkg::KIND_DIFFUSE, 0, 0, -1, 0, 0, 4096));
		send_hit(make_hit(msu_pkg::KIND_DIFFUSE, 32767, 32767, 32767,
			32767, 32767, 32767));
		send_hit(make_hit(msu_pkg::KIND_DIFFUSE, -32768, -32768, -32768,
			-32768, -32768, -32768));
		send_hit(make_hit(msu_pkg::KIND_METAL, 32767, 32767, 32767,
			32767, 32767, 32767));
		send_hit(make_hit(msu_pkg::KIND_METAL, -32768, -32768, -32768,
			-32768, -32768, -32768));
		send_hit(make_hit(msu_pkg::KIND_METAL, -32768, 0, 0, 32767, 0, 0));
		send_hit(make_hit(msu_pkg::KIND_METAL, 4096, -4096, 0, 0, 4096, 0));
		send_hit(make_hit(msu_pkg::KIND_METAL, 0, -4096, 0, 0, 4096, 0));
		send_hit(make_hit(msu_pkg::KIND_METAL, 4096, 0, 0, 0, 4096, 0));
		send_hit(make_hit(msu_pkg::KIND_METAL, 1, 1, 1, 0, 0, 0));
		send_hit(make_hit(msu_pkg::KIND_DIFFUSE, 1, 0, 0, 0, 0, 0));
		send_hit(make_hit(msu_pkg::KIND_METAL, 100, -200, 300, 8192, -8192, 4096));
		send_hit(make_hit(msu_pkg::KIND_DIFFUSE, 2000, 3000, -1000, 0, 0, -32768));
		send_hit(make_hit(msu_pkg::KIND_METAL, -1, 32767, -32768, 1, -1, 1));
		send_hit(make_hit(msu_pkg::KIND_DIFFUSE, -32768, 32767, 0,
			32767, -32768, 0));
	endtask

	initial begin
		logic [47:0] alb [2];
		board = new();
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = msu_pkg::REG_DIFFUSE_ALB;
		cfg_wdata = '0;
		kind = msu_pkg::KIND_DIFFUSE;
		vec_x = '0; vec_y = '0; vec_z = '0;
		normal_x = '0; normal_y = '0; normal_z = '0;
		point_x = '0; point_y = '0; point_z = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		run_random(RAND_PER_PHASE);
		for (int phase = 1; phase < 5; phase++) begin
			drain_results();
			case (phase)
				1: begin
					alb[0] = '1;
					alb[1] = '1;
				end
				3: begin
					alb[0] = '0;
					alb[1] = '1;
				end
				default: begin
					alb[0] = 48'({$urandom, $urandom});
					alb[1] = 48'({$urandom, $urandom});
				end
			endcase
			write_albedo(msu_pkg::REG_DIFFUSE_ALB, alb[0]);
			write_albedo(msu_pkg::REG_METAL_ALB, alb[1]);
			run_random(RAND_PER_PHASE);
		end
		drain_results();

		if (board.errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

/* files.f */
src/msu_pkg.sv
src/msu_sqrt.sv
src/msu_div.sv
src/msu_reflect.sv
src/material_scatter_unit_top.sv
tb/tb.sv
